@@ sv/sparse_triangular_solve_update_assert.svh @@
`ifndef SPARSE_TRIANGULAR_SOLVE_UPDATE_ASSERT_SVH
`define SPARSE_TRIANGULAR_SOLVE_UPDATE_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define STSU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define STSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/stsu_pkg.sv @@
package stsu_pkg;

   localparam int ADDR_W = 10;
   localparam int VECTOR_DEPTH = 2 ** ADDR_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int EXP_W = 14;
   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_READ    = 2'd1,
      REQ_SCATTER = 2'd2,
      REQ_GATHER  = 2'd3
   } req_code_type;

   typedef struct packed {
      req_code_type        op;
      logic [ADDR_W-1:0]   src_addr;
      logic [ADDR_W-1:0]   dst_addr;
      logic [63:0]         coef;
   } cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } fp_result_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_READ_OUT, BK_LOAD_SRC, BK_LOAD_DST, BK_MUL, BK_SUB
   } back_state_type;

   typedef enum logic [2:0] {
      MU_IDLE, MU_NORM, MU_MUL, MU_ALIGN, MU_SHIFT, MU_ROUND
   } mul_state_type;

   typedef enum logic [2:0] {
      SU_IDLE, SU_ALIGN, SU_ADD, SU_NORM, SU_ROUND
   } sub_state_type;

   function automatic logic f64_is_nan(input logic [63:0] v);
      return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
   endfunction

   function automatic logic f64_is_inf(input logic [63:0] v);
      return (v[62:52] == 11'h7FF) && (v[51:0] == 52'd0);
   endfunction

   function automatic logic f64_is_zero(input logic [63:0] v);
      return v[62:0] == 63'd0;
   endfunction

   function automatic logic [63:0] f64_quiet(input logic [63:0] v);
      return v | {12'd0, 1'b1, 51'd0};
   endfunction

   // Rounds to nearest even and packs. The exponent field is at least one; a
   // significand without its top bit set stands for a subnormal at field one.
   function automatic logic [63:0] round_pack(input logic sign, input logic [12:0] ef,
                                              input logic [52:0] m, input logic g,
                                              input logic s);
      logic        inc;
      logic [53:0] mr;
      logic [65:0] pk_sum;
      logic [63:0] res;
      inc = g & (s | m[0]);
      mr = {1'b0, m} + {53'd0, inc};
      pk_sum = {1'b0, ef - 13'd1, 52'd0} + {12'd0, mr};
      if (pk_sum[65:52] >= 14'd2047) begin
         res = {sign, 11'h7FF, 52'd0};
      end else begin
         res = {sign, pk_sum[62:0]};
      end
      return res;
   endfunction

endpackage

@@ sv/sparse_triangular_solve_update.sv @@
// A read request is accepted only into an idle block; its word goes via the read register into
// the result register. An element write is done in the idle state. An update reads both elements,
// multiplies, subtracts and writes back; subnormals and cancellation add normalization steps.
// Throughput is one request at a time in the back end, set by the iterative multiply and subtract.
// Reset is synchronous and active high; it empties the queues but leaves the vector undefined.
module sparse_triangular_solve_update (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  logic [1:0]    req_type,
   input  logic [9:0]    req_pivot_index,
   input  logic [9:0]    req_entry_index,
   input  logic [63:0]   req_coefficient,
   output logic          empty,
   input  logic          pop,
   output logic [63:0]   rsp_read_value
);
   import stsu_pkg::*;

   // The front end decodes each request into source and destination element
   // addresses and holds up to four of them, so requests keep arriving while
   // the back end works through an update or waits for a result to be popped.
   logic      cmd_valid;
   logic      cmd_pop;
   cmd_type   cmd;

   stsu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_pivot_index (req_pivot_index),
      .req_entry_index (req_entry_index),
      .req_coefficient (req_coefficient),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   // The back end owns the vector memory. It runs one request at a time, so
   // every write lands before the next request reads, which removes any
   // read-after-write hazard. An update reads both elements, multiplies with
   // one rounding, subtracts with a second rounding and writes back.
   stsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_read_value (rsp_read_value)
   );

endmodule

@@ sv/stsu_front.sv @@
module stsu_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [1:0]               req_type,
   input  logic [9:0]               req_pivot_index,
   input  logic [9:0]               req_entry_index,
   input  logic [63:0]              req_coefficient,
   output logic                     cmd_valid,
   output stsu_pkg::cmd_type        cmd,
   input  logic                     cmd_pop
);
   import stsu_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   cmd_type             entry;
   logic                do_push, do_pop;

   // Turn the request into the addresses the back end reads and writes.
   always_comb begin
      entry.op = req_code_type'(req_type);
      entry.coef = req_coefficient;
      entry.src_addr = req_pivot_index[ADDR_W-1:0];
      entry.dst_addr = req_pivot_index[ADDR_W-1:0];
      unique case (entry.op) inside
         REQ_WRITE, REQ_READ: begin
            entry.src_addr = req_pivot_index[ADDR_W-1:0];
         end
         REQ_SCATTER: begin
            entry.src_addr = req_pivot_index[ADDR_W-1:0];
            entry.dst_addr = req_entry_index[ADDR_W-1:0];
         end
         REQ_GATHER: begin
            entry.src_addr = req_entry_index[ADDR_W-1:0];
            entry.dst_addr = req_pivot_index[ADDR_W-1:0];
         end
      endcase
   end

   assign full = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign cmd_valid = count_ff != '0;
   assign cmd = queue_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

@@ sv/stsu_fpmul.sv @@
module stsu_fpmul (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [63:0]             op_a,
   input  logic [63:0]             op_b,
   output stsu_pkg::fp_result_type result
);
   import stsu_pkg::*;

   mul_state_type             state_ff, state_in;
   logic                      sign_ff, sign_in;
   logic [52:0]               ma_ff, ma_in, mb_ff, mb_in;
   logic signed [EXP_W-1:0]   ea_ff, ea_in, eb_ff, eb_in;
   logic [1:0]                k_ff, k_in;
   logic [105:0]              acc_ff, acc_in;
   logic [105:0]              nv_ff, nv_in;
   logic [12:0]               ef_ff, ef_in;
   logic [6:0]                sh_ff, sh_in;
   logic [52:0]               m_ff, m_in;
   logic                      g_ff, g_in, s_ff, s_in;
   logic [63:0]               value_ff, value_in;
   logic                      done_ff, done_in;
   logic [17:0]               chunk;
   logic [70:0]               pp;
   logic [105:0]              pp_sh;
   logic signed [EXP_W-1:0]   e_sum, sh_full;
   logic [105:0]              shifted, lost_mask;

   always_comb begin
      case (k_ff)
         2'd0:    chunk = mb_ff[17:0];
         2'd1:    chunk = mb_ff[35:18];
         default: chunk = {1'b0, mb_ff[52:36]};
      endcase
      pp = 71'(ma_ff) * 71'(chunk);
      case (k_ff)
         2'd0:    pp_sh = {35'd0, pp};
         2'd1:    pp_sh = {17'd0, pp, 18'd0};
         default: pp_sh = {pp[69:0], 36'd0};
      endcase
      e_sum = ea_ff + eb_ff - 14'sd1023 + $signed({13'd0, acc_ff[105]});
      sh_full = 14'sd1 - e_sum;
      shifted = nv_ff >> sh_ff;
      lost_mask = (106'd1 << sh_ff) - 106'd1;
   end

   always_comb begin
      state_in = state_ff;
      sign_in = sign_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      ea_in = ea_ff;
      eb_in = eb_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      nv_in = nv_ff;
      ef_in = ef_ff;
      sh_in = sh_ff;
      m_in = m_ff;
      g_in = g_ff;
      s_in = s_ff;
      value_in = value_ff;
      done_in = 1'b0;
      unique case (state_ff)
         MU_IDLE: begin
            if (start) begin
               sign_in = op_a[63] ^ op_b[63];
               ma_in = {op_a[62:52] != 11'd0, op_a[51:0]};
               mb_in = {op_b[62:52] != 11'd0, op_b[51:0]};
               ea_in = (op_a[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, op_a[62:52]});
               eb_in = (op_b[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, op_b[62:52]});
               k_in = 2'd0;
               acc_in = '0;
               if (f64_is_nan(op_a)) begin
                  value_in = f64_quiet(op_a);
                  done_in = 1'b1;
               end else if (f64_is_nan(op_b)) begin
                  value_in = f64_quiet(op_b);
                  done_in = 1'b1;
               end else if ((f64_is_inf(op_a) && f64_is_zero(op_b)) ||
                            (f64_is_zero(op_a) && f64_is_inf(op_b))) begin
                  value_in = DEFAULT_NAN;
                  done_in = 1'b1;
               end else if (f64_is_inf(op_a) || f64_is_inf(op_b)) begin
                  value_in = {op_a[63] ^ op_b[63], 11'h7FF, 52'd0};
                  done_in = 1'b1;
               end else if (f64_is_zero(op_a) || f64_is_zero(op_b)) begin
                  value_in = {op_a[63] ^ op_b[63], 63'd0};
                  done_in = 1'b1;
               end else begin
                  state_in = MU_NORM;
               end
            end
         end
         MU_NORM: begin
            // Subnormal inputs are brought to a leading one, a bit per cycle.
            if (!ma_ff[52]) begin
               ma_in = {ma_ff[51:0], 1'b0};
               ea_in = ea_ff - 14'sd1;
            end
            if (!mb_ff[52]) begin
               mb_in = {mb_ff[51:0], 1'b0};
               eb_in = eb_ff - 14'sd1;
            end
            if (ma_ff[52] && mb_ff[52]) begin
               state_in = MU_MUL;
            end
         end
         MU_MUL: begin
            acc_in = acc_ff + pp_sh;
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               state_in = MU_ALIGN;
            end
         end
         MU_ALIGN: begin
            nv_in = acc_ff[105] ? acc_ff : {acc_ff[104:0], 1'b0};
            if (e_sum > 14'sd0) begin
               ef_in = e_sum[12:0];
               sh_in = 7'd0;
            end else begin
               ef_in = 13'd1;
               sh_in = (sh_full > 14'sd127) ? 7'd127 : sh_full[6:0];
            end
            state_in = MU_SHIFT;
         end
         MU_SHIFT: begin
            m_in = shifted[105:53];
            g_in = shifted[52];
            s_in = (|shifted[51:0]) | (|(nv_ff & lost_mask));
            state_in = MU_ROUND;
         end
         MU_ROUND: begin
            value_in = round_pack(sign_ff, ef_ff, m_ff, g_ff, s_ff);
            done_in = 1'b1;
            state_in = MU_IDLE;
         end
         default: state_in = MU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MU_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff <= sign_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      ea_ff <= ea_in;
      eb_ff <= eb_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
      nv_ff <= nv_in;
      ef_ff <= ef_in;
      sh_ff <= sh_in;
      m_ff <= m_in;
      g_ff <= g_in;
      s_ff <= s_in;
      value_ff <= value_in;
   end

   assign result.done = done_ff;
   assign result.value = value_ff;

endmodule

@@ sv/stsu_fpsub.sv @@
module stsu_fpsub (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [63:0]             op_x,
   input  logic [63:0]             op_y,
   output stsu_pkg::fp_result_type result
);
   import stsu_pkg::*;

   sub_state_type   state_ff, state_in;
   logic [63:0]     big_ff, big_in, small_ff, small_in;
   logic            sign_ff, sign_in, sub_ff, sub_in;
   logic [55:0]     big56_ff, big56_in, al_ff, al_in;
   logic [56:0]     sum_ff, sum_in;
   logic [12:0]     ef_ff, ef_in;
   logic [63:0]     value_ff, value_in;
   logic            done_ff, done_in;
   logic [63:0]     yn, big_val, small_val;
   logic [10:0]     eb, es, d;
   logic [5:0]      dcl;
   logic [55:0]     small56, sm_shift, sm_mask;

   always_comb begin
      yn = {~op_y[63], op_y[62:0]};
      if (op_x[62:0] >= yn[62:0]) begin
         big_val = op_x;
         small_val = yn;
      end else begin
         big_val = yn;
         small_val = op_x;
      end
      eb = (big_ff[62:52] == 11'd0) ? 11'd1 : big_ff[62:52];
      es = (small_ff[62:52] == 11'd0) ? 11'd1 : small_ff[62:52];
      d = eb - es;
      dcl = (d > 11'd63) ? 6'd63 : d[5:0];
      small56 = {small_ff[62:52] != 11'd0, small_ff[51:0], 3'b000};
      sm_shift = small56 >> dcl;
      sm_mask = (56'd1 << dcl) - 56'd1;
   end

   always_comb begin
      state_in = state_ff;
      big_in = big_ff;
      small_in = small_ff;
      sign_in = sign_ff;
      sub_in = sub_ff;
      big56_in = big56_ff;
      al_in = al_ff;
      sum_in = sum_ff;
      ef_in = ef_ff;
      value_in = value_ff;
      done_in = 1'b0;
      unique case (state_ff)
         SU_IDLE: begin
            if (start) begin
               big_in = big_val;
               small_in = small_val;
               sign_in = big_val[63];
               sub_in = op_x[63] ^ yn[63];
               if (f64_is_nan(op_x)) begin
                  value_in = f64_quiet(op_x);
                  done_in = 1'b1;
               end else if (f64_is_nan(op_y)) begin
                  value_in = f64_quiet(op_y);
                  done_in = 1'b1;
               end else if (f64_is_inf(op_x) && f64_is_inf(yn) && (op_x[63] != yn[63])) begin
                  value_in = DEFAULT_NAN;
                  done_in = 1'b1;
               end else if (f64_is_inf(op_x)) begin
                  value_in = op_x;
                  done_in = 1'b1;
               end else if (f64_is_inf(yn)) begin
                  value_in = yn;
                  done_in = 1'b1;
               end else if (f64_is_zero(op_x) && f64_is_zero(yn)) begin
                  value_in = {op_x[63] & yn[63], 63'd0};
                  done_in = 1'b1;
               end else if (f64_is_zero(yn)) begin
                  value_in = op_x;
                  done_in = 1'b1;
               end else if (f64_is_zero(op_x)) begin
                  value_in = yn;
                  done_in = 1'b1;
               end else begin
                  state_in = SU_ALIGN;
               end
            end
         end
         SU_ALIGN: begin
            big56_in = {big_ff[62:52] != 11'd0, big_ff[51:0], 3'b000};
            al_in = {sm_shift[55:1], sm_shift[0] | (|(small56 & sm_mask))};
            ef_in = {2'b00, eb};
            state_in = SU_ADD;
         end
         SU_ADD: begin
            sum_in = sub_ff ? {1'b0, big56_ff} - {1'b0, al_ff}
                            : {1'b0, big56_ff} + {1'b0, al_ff};
            state_in = SU_NORM;
         end
         SU_NORM: begin
            // Exact cancellation gives positive zero.
            if (sum_ff == 57'd0) begin
               value_in = 64'd0;
               done_in = 1'b1;
               state_in = SU_IDLE;
            end else if (sum_ff[56]) begin
               sum_in = {1'b0, sum_ff[56:2], sum_ff[1] | sum_ff[0]};
               ef_in = ef_ff + 13'd1;
               state_in = SU_ROUND;
            end else if (sum_ff[55] || ef_ff == 13'd1) begin
               state_in = SU_ROUND;
            end else begin
               sum_in = {sum_ff[55:0], 1'b0};
               ef_in = ef_ff - 13'd1;
            end
         end
         SU_ROUND: begin
            value_in = round_pack(sign_ff, ef_ff, sum_ff[55:3], sum_ff[2], |sum_ff[1:0]);
            done_in = 1'b1;
            state_in = SU_IDLE;
         end
         default: state_in = SU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SU_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      big_ff <= big_in;
      small_ff <= small_in;
      sign_ff <= sign_in;
      sub_ff <= sub_in;
      big56_ff <= big56_in;
      al_ff <= al_in;
      sum_ff <= sum_in;
      ef_ff <= ef_in;
      value_ff <= value_in;
   end

   assign result.done = done_ff;
   assign result.value = value_ff;

endmodule

@@ sv/stsu_back.sv @@
module stsu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  stsu_pkg::cmd_type    cmd,
   output logic                 cmd_pop,
   output logic                 empty,
   input  logic                 pop,
   output logic [63:0]          rsp_read_value
);
   import stsu_pkg::*;
   `include "sparse_triangular_solve_update_assert.svh"

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [63:0]         src_val_ff, src_val_in, dst_val_ff, dst_val_in;
   logic                out_valid_ff, out_valid_in;
   logic [63:0]         out_value_ff, out_value_in;
   logic [63:0]         vector_mem [VECTOR_DEPTH];
   logic [63:0]         rdata_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [63:0]         mem_wdata;
   logic                mul_start, sub_start, out_set;
   fp_result_type       mul_res, sub_res;

   stsu_fpmul u_fpmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (src_val_ff),
      .op_b   (cmd_ff.coef),
      .result (mul_res)
   );

   stsu_fpsub u_fpsub (
      .clock  (clock),
      .reset  (reset),
      .start  (sub_start),
      .op_x   (dst_val_ff),
      .op_y   (mul_res.value),
      .result (sub_res)
   );

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      src_val_in = src_val_ff;
      dst_val_in = dst_val_ff;
      cmd_pop = 1'b0;
      mem_we = 1'b0;
      mem_waddr = cmd_ff.dst_addr;
      mem_wdata = sub_res.value;
      mem_raddr = cmd_ff.src_addr;
      mul_start = 1'b0;
      sub_start = 1'b0;
      out_set = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op) inside
                  REQ_WRITE: begin
                     cmd_pop = 1'b1;
                     mem_we = 1'b1;
                     mem_waddr = cmd.dst_addr;
                     mem_wdata = cmd.coef;
                  end
                  REQ_READ: begin
                     // A read waits until the result register is free.
                     if (!out_valid_ff) begin
                        cmd_pop = 1'b1;
                        mem_raddr = cmd.src_addr;
                        state_in = BK_READ_OUT;
                     end
                  end
                  REQ_SCATTER, REQ_GATHER: begin
                     cmd_pop = 1'b1;
                     cmd_in = cmd;
                     mem_raddr = cmd.src_addr;
                     state_in = BK_LOAD_SRC;
                  end
               endcase
            end
         end
         BK_READ_OUT: begin
            out_set = 1'b1;
            state_in = BK_IDLE;
         end
         BK_LOAD_SRC: begin
            src_val_in = rdata_ff;
            mem_raddr = cmd_ff.dst_addr;
            state_in = BK_LOAD_DST;
         end
         BK_LOAD_DST: begin
            dst_val_in = rdata_ff;
            mul_start = 1'b1;
            state_in = BK_MUL;
         end
         BK_MUL: begin
            if (mul_res.done) begin
               sub_start = 1'b1;
               state_in = BK_SUB;
            end
         end
         BK_SUB: begin
            if (sub_res.done) begin
               mem_we = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_set) begin
         out_valid_in = 1'b1;
      end else if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      out_value_in = out_set ? rdata_ff : out_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      src_val_ff <= src_val_in;
      dst_val_ff <= dst_val_in;
      out_value_ff <= out_value_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vector_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= vector_mem[mem_raddr];
   end

   assign empty = !out_valid_ff;
   assign rsp_read_value = out_value_ff;

   `STSU_ASSERT_NEXT(a_read_fills_out, clock, reset, state_ff == BK_READ_OUT, out_valid_ff, "read data not presented")
   `STSU_ASSERT_SAME(a_pop_only_idle, clock, reset, cmd_pop, state_ff == BK_IDLE, "command taken while busy")
   `STSU_ASSERT_SAME(a_mul_done_in_mul, clock, reset, mul_res.done, state_ff == BK_MUL, "stray product")
   `STSU_ASSERT_SAME(a_sub_done_in_sub, clock, reset, sub_res.done, state_ff == BK_SUB, "stray difference")

endmodule
